// ----- design/vic_pkg.sv -----
// ---------------------------------------------------------------------------
// vic_pkg
// Widths and constants shared by the vortex influence coefficient pipeline
// and its checker.
// ---------------------------------------------------------------------------
package vic_pkg;

  // field widths
  localparam int COORD_W  = 20;
  localparam int NORM_W   = 18;
  localparam int FLOOR_W  = 21;
  localparam int COEF_W   = 32;

  // datapath widths
  localparam int DIFF_W   = COORD_W + 1;          // exact coordinate difference
  localparam int SQ_W     = 2 * DIFF_W - 1;       // one squared difference
  localparam int RSQ_W    = SQ_W + 1;             // sum of squares, also divisor
  localparam int PROD_W   = DIFF_W + NORM_W;      // one cross product
  localparam int NUM_W    = PROD_W + 1;           // numerator, signed
  localparam int MAG_W    = NUM_W - 1;            // numerator magnitude
  localparam int MAG_LO_W = 20;
  localparam int MAG_HI_W = MAG_W - MAG_LO_W;
  localparam int K_W      = 30;
  localparam int FULL_W   = MAG_W + K_W;          // magnitude times 1/(2*pi)

  // round(2^32 / (2*pi))
  localparam logic [K_W-1:0] INV_TWO_PI = 30'd683565276;

  // quotient bits resolved by the divider, one per stage
  localparam int QUO_W    = COEF_W;
  localparam int DIV_STEPS = QUO_W;

  // register count from input to result strobe
  localparam int PIPE_DEPTH = 7 + DIV_STEPS + 1;

  // saturation limits
  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

endpackage

// ----- design/vortex_influence_coefficient.sv -----
// ---------------------------------------------------------------------------
// vortex_influence_coefficient
// Normal velocity induced at a collocation point by a unit point vortex,
// (dy*nx - dx*ny) / (2*pi*max(r_sq, floor)), saturated to signed Q15.16.
// ---------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   --------------------------------------
//  input     start && !busy              collocation_x/y, vortex_x/y, normal_x/y
//  result    done (one-cycle strobe)     coefficient, saturated
//  config    cfg_valid && cfg_ready      cfg_data (rsq_floor)
//
//  one transaction enters per cycle while busy is low; results come from the
//  32-step restoring divider, one quotient bit a stage
//  busy is high only during reset; results are never held back
//  synchronous reset clears all valid bits and sets rsq_floor to 1
// ---------------------------------------------------------------------------
module vortex_influence_coefficient
  import vic_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // input transactions
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  collocation_x,
  input  logic signed [COORD_W-1:0]  collocation_y,
  input  logic signed [COORD_W-1:0]  vortex_x,
  input  logic signed [COORD_W-1:0]  vortex_y,
  input  logic signed [NORM_W-1:0]   normal_x,
  input  logic signed [NORM_W-1:0]   normal_y,
  // results
  output logic                       done,
  output logic signed [COEF_W-1:0]   coefficient,
  output logic                       saturated,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [FLOOR_W-1:0]         cfg_data
);

  localparam int SHIFT    = 32 - COORD_FRAC_BITS;
  localparam int SCALED_W = FULL_W - SHIFT;
  localparam int HIGH_W   = SCALED_W - QUO_W;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [RSQ_W-1:0]  den;
    logic [RSQ_W-1:0]  rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

  logic               accept;
  logic [FLOOR_W-1:0] rsq_floor;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // floor register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsq_floor <= FLOOR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      rsq_floor <= cfg_data;
    end
  end

  // stage 1: differences
  logic                     s1_valid;
  logic signed [DIFF_W-1:0] s1_dx, s1_dy;
  logic signed [NORM_W-1:0] s1_nx, s1_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_dx <= {collocation_x[COORD_W-1], collocation_x} - {vortex_x[COORD_W-1], vortex_x};
    s1_dy <= {collocation_y[COORD_W-1], collocation_y} - {vortex_y[COORD_W-1], vortex_y};
    s1_nx <= normal_x;
    s1_ny <= normal_y;
  end

  // stage 2: squares and cross products
  logic signed [2*DIFF_W-1:0] sq_x_full, sq_y_full;
  logic                       s2_valid;
  logic [SQ_W-1:0]            s2_sq_x, s2_sq_y;
  logic signed [PROD_W-1:0]   s2_dy_nx, s2_dx_ny;

  assign sq_x_full = s1_dx * s1_dx;
  assign sq_y_full = s1_dy * s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sq_x  <= sq_x_full[SQ_W-1:0];
    s2_sq_y  <= sq_y_full[SQ_W-1:0];
    s2_dy_nx <= s1_dy * s1_nx;
    s2_dx_ny <= s1_dx * s1_ny;
  end

  // stage 3: squared distance and numerator
  logic              s3_valid;
  logic [RSQ_W-1:0]  s3_rsq;
  logic [NUM_W-1:0]  s3_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_rsq <= {1'b0, s2_sq_x} + {1'b0, s2_sq_y};
    s3_num <= {s2_dy_nx[PROD_W-1], s2_dy_nx} - {s2_dx_ny[PROD_W-1], s2_dx_ny};
  end

  // stage 4: floored divisor and numerator magnitude
  logic [RSQ_W-1:0] floor_ext, den_max, den_sel;
  logic [NUM_W-1:0] num_abs;
  logic             s4_valid, s4_neg;
  logic [RSQ_W-1:0] s4_den;
  logic [MAG_W-1:0] s4_mag;

  always_comb begin
    floor_ext = {{(RSQ_W-FLOOR_W){1'b0}}, rsq_floor};
    den_max   = (s3_rsq < floor_ext) ? floor_ext : s3_rsq;
    den_sel   = (den_max == '0) ? {{(RSQ_W-1){1'b0}}, 1'b1} : den_max;
    num_abs   = s3_num[NUM_W-1] ? (~s3_num + 1'b1) : s3_num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_neg <= s3_num[NUM_W-1];
    s4_den <= den_sel;
    s4_mag <= num_abs[MAG_W-1:0];
  end

  // stage 5: partial products with 1/(2*pi)
  logic                      s5_valid, s5_neg;
  logic [RSQ_W-1:0]          s5_den;
  logic [MAG_LO_W+K_W-1:0]   s5_lo_k;
  logic [MAG_HI_W+K_W-1:0]   s5_hi_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_neg  <= s4_neg;
    s5_den  <= s4_den;
    s5_lo_k <= s4_mag[MAG_LO_W-1:0] * INV_TWO_PI;
    s5_hi_k <= s4_mag[MAG_W-1:MAG_LO_W] * INV_TWO_PI;
  end

  // stage 6: combine and scale the dividend
  logic [FULL_W-1:0]   full_prod;
  logic                s6_valid, s6_neg;
  logic [RSQ_W-1:0]    s6_den;
  logic [SCALED_W-1:0] s6_scaled;

  assign full_prod = {s5_hi_k, {MAG_LO_W{1'b0}}}
                   + {{(FULL_W-MAG_LO_W-K_W){1'b0}}, s5_lo_k};

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_neg    <= s5_neg;
    s6_den    <= s5_den;
    s6_scaled <= full_prod[FULL_W-1:SHIFT];
  end

  // stage 7: quotient overflow check and divider setup
  logic [RSQ_W-1:0] high_ext;
  logic             div_valid [0:DIV_STEPS];
  div_stage_t       div_pipe  [0:DIV_STEPS];

  assign high_ext = {{(RSQ_W-HIGH_W){1'b0}}, s6_scaled[SCALED_W-1:QUO_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else begin
      div_valid[0] <= s6_valid;
    end
    div_pipe[0].neg <= s6_neg;
    div_pipe[0].ovf <= (high_ext >= s6_den);
    div_pipe[0].den <= s6_den;
    div_pipe[0].rem <= high_ext;
    div_pipe[0].low <= s6_scaled[QUO_W-1:0];
    div_pipe[0].quo <= '0;
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [RSQ_W:0]   trial;
    logic             fits;
    logic [RSQ_W:0]   diff;
    logic [RSQ_W-1:0] rem_next;

    always_comb begin
      trial    = {div_pipe[j].rem, div_pipe[j].low[QUO_W-1]};
      fits     = trial >= {1'b0, div_pipe[j].den};
      diff     = trial - {1'b0, div_pipe[j].den};
      rem_next = fits ? diff[RSQ_W-1:0] : trial[RSQ_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[j+1] <= 1'b0;
      end else begin
        div_valid[j+1] <= div_valid[j];
      end
      div_pipe[j+1].neg <= div_pipe[j].neg;
      div_pipe[j+1].ovf <= div_pipe[j].ovf;
      div_pipe[j+1].den <= div_pipe[j].den;
      div_pipe[j+1].rem <= rem_next;
      div_pipe[j+1].low <= {div_pipe[j].low[QUO_W-2:0], 1'b0};
      div_pipe[j+1].quo <= {div_pipe[j].quo[QUO_W-2:0], fits};
    end
  end

  // sign and saturation
  div_stage_t         last;
  logic [COEF_W-1:0]  coef_next;
  logic               sat_next;

  assign last = div_pipe[DIV_STEPS];

  always_comb begin
    priority if (last.ovf) begin
      sat_next  = 1'b1;
      coef_next = last.neg ? COEF_MIN : COEF_MAX;
    end else if (last.neg) begin
      sat_next  = (last.quo > COEF_MIN);
      coef_next = sat_next ? COEF_MIN : (~last.quo + 1'b1);
    end else begin
      sat_next  = (last.quo > COEF_MAX);
      coef_next = sat_next ? COEF_MAX : last.quo;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid[DIV_STEPS];
    end
    coefficient <= coef_next;
    saturated   <= sat_next;
  end

endmodule

// ----- design/vic_checker.sv -----
// ---------------------------------------------------------------------------
// vic_checker
// Port-level checks on latency, reset and saturation of the vortex influence
// coefficient pipeline.
// ---------------------------------------------------------------------------
module vic_checker
  import vic_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [COEF_W-1:0]  coefficient,
  input logic                      saturated,
  input logic signed [COORD_W-1:0] collocation_x,
  input logic signed [COORD_W-1:0] collocation_y,
  input logic signed [COORD_W-1:0] vortex_x,
  input logic signed [COORD_W-1:0] vortex_y
);

  // every accepted transaction yields one result at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_DEPTH done)
    else $error("result missing after accepted transaction");

  // no result without a transaction accepted at that latency
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without matching transaction");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // a clipped result sits at one of the two limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (coefficient == COEF_MAX) || (coefficient == COEF_MIN))
    else $error("saturated result off the limits");

  // coincident points give a zero, unclipped coefficient
  a_coincident: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (collocation_x == vortex_x) && (collocation_y == vortex_y)
      |-> ##PIPE_DEPTH (coefficient == '0) && !saturated)
    else $error("nonzero coefficient for coincident points");

endmodule

bind vortex_influence_coefficient vic_checker u_vic_checker (.*);
